// ===== rtl/c8x_pkg.sv =====
`default_nettype none
package c8x_pkg;

  localparam int SCREEN_WIDTH = 64;
  localparam logic [11:0] PC_START = 12'h200;
  localparam logic [11:0] FONT_BASE = 12'h050;
  localparam logic [11:0] FONT_BYTES = 12'd80;
  localparam logic [3:0] FLAG_REG = 4'hF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BAD       = 2'd3
  } status_t;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // opcode groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;

  // ALU group operations (low nibble of 8xyN)
  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  typedef struct packed {
    logic [7:0] result;
    logic       flag;
    logic       flag_we;
    logic       bad;
  } alu_res_t;

  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] b;
    case (idx)
      7'd0: b = 8'hF0;  7'd1: b = 8'h90;  7'd2: b = 8'h90;  7'd3: b = 8'h90;
      7'd4: b = 8'hF0;  7'd5: b = 8'h20;  7'd6: b = 8'h60;  7'd7: b = 8'h20;
      7'd8: b = 8'h20;  7'd9: b = 8'h70;  7'd10: b = 8'hF0; 7'd11: b = 8'h10;
      7'd12: b = 8'hF0; 7'd13: b = 8'h80; 7'd14: b = 8'hF0; 7'd15: b = 8'hF0;
      7'd16: b = 8'h10; 7'd17: b = 8'hF0; 7'd18: b = 8'h10; 7'd19: b = 8'hF0;
      7'd20: b = 8'h90; 7'd21: b = 8'h90; 7'd22: b = 8'hF0; 7'd23: b = 8'h10;
      7'd24: b = 8'h10; 7'd25: b = 8'hF0; 7'd26: b = 8'h80; 7'd27: b = 8'hF0;
      7'd28: b = 8'h10; 7'd29: b = 8'hF0; 7'd30: b = 8'hF0; 7'd31: b = 8'h80;
      7'd32: b = 8'hF0; 7'd33: b = 8'h90; 7'd34: b = 8'hF0; 7'd35: b = 8'hF0;
      7'd36: b = 8'h10; 7'd37: b = 8'h20; 7'd38: b = 8'h40; 7'd39: b = 8'h40;
      7'd40: b = 8'hF0; 7'd41: b = 8'h90; 7'd42: b = 8'hF0; 7'd43: b = 8'h90;
      7'd44: b = 8'hF0; 7'd45: b = 8'hF0; 7'd46: b = 8'h90; 7'd47: b = 8'hF0;
      7'd48: b = 8'h10; 7'd49: b = 8'hF0; 7'd50: b = 8'hF0; 7'd51: b = 8'h90;
      7'd52: b = 8'hF0; 7'd53: b = 8'h90; 7'd54: b = 8'h90; 7'd55: b = 8'hE0;
      7'd56: b = 8'h90; 7'd57: b = 8'hE0; 7'd58: b = 8'h90; 7'd59: b = 8'hE0;
      7'd60: b = 8'hF0; 7'd61: b = 8'h80; 7'd62: b = 8'h80; 7'd63: b = 8'h80;
      7'd64: b = 8'hF0; 7'd65: b = 8'hE0; 7'd66: b = 8'h90; 7'd67: b = 8'h90;
      7'd68: b = 8'h90; 7'd69: b = 8'hE0; 7'd70: b = 8'hF0; 7'd71: b = 8'h80;
      7'd72: b = 8'hF0; 7'd73: b = 8'h80; 7'd74: b = 8'hF0; 7'd75: b = 8'hF0;
      7'd76: b = 8'h80; 7'd77: b = 8'hF0; 7'd78: b = 8'h80; 7'd79: b = 8'h80;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/c8x_ram.sv =====
`default_nettype none
module c8x_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/c8x_alu.sv =====
`default_nettype none
module c8x_alu
  import c8x_pkg::*;
(
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  input  wire logic [3:0] op,
  output alu_res_t        res
);

  logic [8:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  // compute result and flag of the 8xyN group
  always_comb begin
    res = '0;
    case (op)
      ALU_MOV: res.result = b;
      ALU_OR:  res.result = a | b;
      ALU_AND: res.result = a & b;
      ALU_XOR: res.result = a ^ b;
      ALU_ADD: begin
        res.result  = sum[7:0];
        res.flag    = sum[8];
        res.flag_we = 1'b1;
      end
      ALU_SUB: begin
        res.result  = a - b;
        res.flag    = (a >= b);
        res.flag_we = 1'b1;
      end
      ALU_SHR: begin
        res.result  = {1'b0, a[7:1]};
        res.flag    = a[0];
        res.flag_we = 1'b1;
      end
      ALU_SUBN: begin
        res.result  = b - a;
        res.flag    = (b >= a);
        res.flag_we = 1'b1;
      end
      ALU_SHL: begin
        res.result  = {a[6:0], 1'b0};
        res.flag    = a[7];
        res.flag_we = 1'b1;
      end
      default: res.bad = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/chip8_instruction_execute.sv =====
`default_nettype none
// CHIP-8 execution unit. One request is taken at a time and answered with
// one result. After reset a clearing pass over all MEMORY_BYTES bytes loads
// the font at 0x50 and zeroes the rest of memory; no request is taken during it.
// Memory writes and unsupported commands go straight to S_DONE, screen row
// reads pass S_SREAD, opcodes pass S_RX, S_RY and S_EXEC, and ALU ops with a
// flag add S_FLAG (registers are read one at a time from the register RAM).
// A draw stays in S_PREP until index and row are in range; each row then costs
// one memory read and one screen read-modify-write. 00E0 clears the screen at once.
// A new request is taken while the previous result still waits at the output.
module chip8_instruction_execute
  import c8x_pkg::*;
#(
  parameter int MEMORY_BYTES  = 4096,
  parameter int STACK_ENTRIES = 16,
  parameter int SCREEN_HEIGHT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [15:0] in_opcode,
  input  wire logic [11:0] in_address,
  input  wire logic [7:0]  in_data,
  input  wire logic [7:0]  in_random_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [11:0]      out_program_counter,
  output logic [7:0]       out_flag_value,
  output logic [63:0]      out_row_data
);

  localparam int MAW = $clog2(MEMORY_BYTES);
  localparam int SKW = $clog2(STACK_ENTRIES);
  localparam int DW  = $clog2(STACK_ENTRIES + 1);
  localparam int HW  = $clog2(SCREEN_HEIGHT);
  localparam logic [11:0] MEM_TOP = 12'(MEMORY_BYTES - 1);
  localparam logic [12:0] MEM_N   = 13'(MEMORY_BYTES);
  localparam logic [7:0]  SCR_N   = 8'(SCREEN_HEIGHT);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_RX    = 11'b00000000100,
    S_RY    = 11'b00000001000,
    S_EXEC  = 11'b00000010000,
    S_FLAG  = 11'b00000100000,
    S_PREP  = 11'b00001000000,
    S_DMEM  = 11'b00010000000,
    S_DROW  = 11'b00100000000,
    S_SREAD = 11'b01000000000,
    S_DONE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [MAW-1:0]           clr_r, clr_nxt;
  logic [15:0]              op_r, op_nxt;
  logic [11:0]              addr_r, addr_nxt;
  logic [7:0]               rnd_r, rnd_nxt;
  logic [7:0]               vx_r, vx_nxt;
  logic [7:0]               vy_r, vy_nxt;
  logic [11:0]              pc_r, pc_nxt;
  logic [11:0]              idx_r, idx_nxt;
  logic [DW-1:0]            depth_r, depth_nxt;
  logic [7:0]               vf_r, vf_nxt;
  logic                     flag_r, flag_nxt;
  logic [15:0]              reg_ok_r, reg_ok_nxt;
  logic [SCREEN_HEIGHT-1:0] scr_ok_r, scr_ok_nxt;
  status_t                  st_r, st_nxt;
  logic [63:0]              row_r, row_nxt;
  logic [11:0]              sp_r, sp_nxt;
  logic [7:0]               y_r, y_nxt;
  logic [3:0]               rows_r, rows_nxt;
  logic                     hit_r, hit_nxt;
  logic                     ov_r, ov_nxt;
  logic [1:0]               ost_r, ost_nxt;
  logic [11:0]              opc_r, opc_nxt;
  logic [7:0]               ovf_r, ovf_nxt;
  logic [63:0]              orow_r, orow_nxt;

  // memory ports
  logic           mem_we;
  logic [MAW-1:0] mem_waddr, mem_raddr;
  logic [7:0]     mem_wdata, mem_rdata;
  logic           reg_we;
  logic [3:0]     reg_waddr, reg_raddr;
  logic [7:0]     reg_wdata, reg_rdata;
  logic           stk_we;
  logic [SKW-1:0] stk_waddr, stk_raddr;
  logic [11:0]    stk_wdata, stk_rdata;
  logic           scr_we;
  logic [HW-1:0]  scr_waddr, scr_raddr;
  logic [63:0]    scr_wdata, scr_rdata;

  alu_res_t   alu;
  logic [3:0] op_x, op_y, op_n, op_grp;
  logic [11:0] nnn, pc_adv, clr_off;
  logic [7:0] kk, reg_val;
  logic [63:0] old_row, mask;
  logic       accept;

  assign op_grp = op_r[15:12];
  assign op_x   = op_r[11:8];
  assign op_y   = op_r[7:4];
  assign op_n   = op_r[3:0];
  assign nnn    = op_r[11:0];
  assign kk     = op_r[7:0];
  assign pc_adv = pc_r + 12'd2;
  assign clr_off = 12'(clr_r) - FONT_BASE;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  c8x_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );
  c8x_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );
  c8x_ram #(.WIDTH(12), .DEPTH(STACK_ENTRIES)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );
  c8x_ram #(.WIDTH(64), .DEPTH(SCREEN_HEIGHT)) u_screen (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rdata)
  );

  c8x_alu u_alu (.a(vx_r), .b(vy_r), .op(op_n), .res(alu));

  // hold the top of the stack at the read port
  assign stk_raddr = SKW'(depth_r - 1'b1);
  assign stk_waddr = depth_r[SKW-1:0];
  assign stk_wdata = pc_adv;

  // register read: an entry never written reads as zero
  assign reg_val = reg_ok_r[state_r == S_RX ? op_x : (op_grp == GRP_JPV ? 4'd0 : op_y)]
                   ? reg_rdata : 8'd0;
  assign old_row = scr_ok_r[y_r[HW-1:0]] ? scr_rdata : 64'd0;
  assign mask    = {mem_rdata, 56'd0} >> vx_r[5:0];

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    rnd_nxt    = rnd_r;
    vx_nxt     = vx_r;
    vy_nxt     = vy_r;
    pc_nxt     = pc_r;
    idx_nxt    = idx_r;
    depth_nxt  = depth_r;
    vf_nxt     = vf_r;
    flag_nxt   = flag_r;
    reg_ok_nxt = reg_ok_r;
    scr_ok_nxt = scr_ok_r;
    st_nxt     = st_r;
    row_nxt    = row_r;
    sp_nxt     = sp_r;
    y_nxt      = y_r;
    rows_nxt   = rows_r;
    hit_nxt    = hit_r;
    ov_nxt     = ov_r;
    ost_nxt    = ost_r;
    opc_nxt    = opc_r;
    ovf_nxt    = ovf_r;
    orow_nxt   = orow_r;

    mem_we    = 1'b0;
    mem_waddr = in_address[MAW-1:0];
    mem_wdata = in_data;
    mem_raddr = sp_r[MAW-1:0];
    reg_we    = 1'b0;
    reg_waddr = op_x;
    reg_wdata = 8'd0;
    reg_raddr = (state_r == S_RX) ? ((op_grp == GRP_JPV) ? 4'd0 : op_y)
                                  : in_opcode[11:8];
    stk_we    = 1'b0;
    scr_we    = 1'b0;
    scr_waddr = y_r[HW-1:0];
    scr_wdata = old_row ^ mask;
    scr_raddr = (state_r == S_IDLE) ? in_address[HW-1:0] : y_r[HW-1:0];

    // release the output register once taken
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      // load font and zero the rest of memory
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = (clr_off < FONT_BYTES) ? font_byte(clr_off[6:0]) : 8'd0;
        clr_nxt   = clr_r + 1'b1;
        if (12'(clr_r) == MEM_TOP) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_opcode;
          addr_nxt = in_address;
          rnd_nxt  = in_random_byte;
          st_nxt   = ST_OK;
          row_nxt  = 64'd0;
          case (in_command)
            CMD_EXEC: state_nxt = S_RX;
            CMD_WRITE: begin
              mem_we    = (in_address <= MEM_TOP);
              state_nxt = S_DONE;
            end
            CMD_READ: state_nxt = S_SREAD;
            default: begin
              st_nxt    = ST_BAD;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SREAD: begin
        if (addr_r < 12'(SCREEN_HEIGHT) && scr_ok_r[addr_r[HW-1:0]]) begin
          row_nxt = scr_rdata;
        end
        state_nxt = S_DONE;
      end
      S_RX: begin
        vx_nxt    = reg_val;
        state_nxt = S_RY;
      end
      S_RY: begin
        vy_nxt    = reg_val;
        state_nxt = S_EXEC;
      end
      // apply the opcode
      S_EXEC: begin
        pc_nxt    = pc_adv;
        state_nxt = S_DONE;
        case (op_grp)
          GRP_SYS: begin
            if (op_r == OP_CLS) begin
              scr_ok_nxt = '0;
            end else if (op_r == OP_RET) begin
              if (depth_r == '0) begin
                st_nxt = ST_UNDERFLOW;
              end else begin
                depth_nxt = depth_r - 1'b1;
                pc_nxt    = stk_rdata;
              end
            end else begin
              st_nxt = ST_BAD;
            end
          end
          GRP_JP: pc_nxt = nnn;
          GRP_CALL: begin
            if (32'(depth_r) >= STACK_ENTRIES) begin
              st_nxt = ST_OVERFLOW;
            end else begin
              stk_we    = 1'b1;
              depth_nxt = depth_r + 1'b1;
              pc_nxt    = nnn;
            end
          end
          GRP_SE:   if (vx_r == kk) pc_nxt = pc_r + 12'd4;
          GRP_SNE:  if (vx_r != kk) pc_nxt = pc_r + 12'd4;
          GRP_SER:  if (vx_r == vy_r) pc_nxt = pc_r + 12'd4;
          GRP_SNER: if (vx_r != vy_r) pc_nxt = pc_r + 12'd4;
          GRP_LD: begin
            reg_we    = 1'b1;
            reg_wdata = kk;
          end
          GRP_ADD: begin
            reg_we    = 1'b1;
            reg_wdata = vx_r + kk;
          end
          GRP_ALU: begin
            if (alu.bad) begin
              st_nxt = ST_BAD;
            end else begin
              reg_we    = 1'b1;
              reg_wdata = alu.result;
              flag_nxt  = alu.flag;
              if (alu.flag_we) begin
                state_nxt = S_FLAG;
              end
            end
          end
          GRP_LDI: idx_nxt = nnn;
          GRP_JPV: pc_nxt = nnn + {4'd0, vy_r};
          GRP_RND: begin
            reg_we    = 1'b1;
            reg_wdata = rnd_r & kk;
          end
          GRP_DRW: begin
            sp_nxt    = idx_r;
            y_nxt     = vy_r;
            rows_nxt  = 4'd0;
            hit_nxt   = 1'b0;
            state_nxt = S_PREP;
          end
          default: st_nxt = ST_BAD;
        endcase
      end
      // bring index into memory range and row into screen range
      S_PREP: begin
        if ({1'b0, sp_r} >= MEM_N) begin
          sp_nxt = sp_r - MEM_N[11:0];
        end
        if (y_r >= SCR_N) begin
          y_nxt = y_r - SCR_N;
        end
        if ({1'b0, sp_r} < MEM_N && y_r < SCR_N) begin
          if (op_n == 4'd0) begin
            flag_nxt  = 1'b0;
            state_nxt = S_FLAG;
          end else begin
            state_nxt = S_DMEM;
          end
        end
      end
      S_DMEM: state_nxt = S_DROW;
      // merge sprite byte into the row
      S_DROW: begin
        scr_we                  = 1'b1;
        scr_ok_nxt[y_r[HW-1:0]] = 1'b1;
        hit_nxt  = hit_r | (|(old_row & mask));
        rows_nxt = rows_r + 4'd1;
        y_nxt    = y_r + 8'd1;
        sp_nxt   = (sp_r == MEM_TOP) ? 12'd0 : sp_r + 12'd1;
        if (rows_r + 4'd1 == op_n || y_r + 8'd1 >= SCR_N) begin
          flag_nxt  = hit_r | (|(old_row & mask));
          state_nxt = S_FLAG;
        end else begin
          state_nxt = S_DMEM;
        end
      end
      S_FLAG: begin
        reg_we    = 1'b1;
        reg_waddr = FLAG_REG;
        reg_wdata = {7'd0, flag_r};
        state_nxt = S_DONE;
      end
      // hand the result to the output register
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ost_nxt   = st_r;
          opc_nxt   = pc_r;
          ovf_nxt   = vf_r;
          orow_nxt  = row_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // track valid entries and the flag register copy
    if (reg_we) begin
      reg_ok_nxt[reg_waddr] = 1'b1;
      if (reg_waddr == FLAG_REG) begin
        vf_nxt = reg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      pc_r     <= PC_START;
      idx_r    <= 12'd0;
      depth_r  <= '0;
      vf_r     <= 8'd0;
      reg_ok_r <= '0;
      scr_ok_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      pc_r     <= pc_nxt;
      idx_r    <= idx_nxt;
      depth_r  <= depth_nxt;
      vf_r     <= vf_nxt;
      reg_ok_r <= reg_ok_nxt;
      scr_ok_r <= scr_ok_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    addr_r <= addr_nxt;
    rnd_r  <= rnd_nxt;
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    flag_r <= flag_nxt;
    st_r   <= st_nxt;
    row_r  <= row_nxt;
    sp_r   <= sp_nxt;
    y_r    <= y_nxt;
    rows_r <= rows_nxt;
    hit_r  <= hit_nxt;
    ost_r  <= ost_nxt;
    opc_r  <= opc_nxt;
    ovf_r  <= ovf_nxt;
    orow_r <= orow_nxt;
  end

  assign out_valid           = ov_r;
  assign out_status          = ost_r;
  assign out_program_counter = opc_r;
  assign out_flag_value      = ovf_r;
  assign out_row_data        = orow_r;

endmodule
`default_nettype wire

// ===== tb/chip8_instruction_execute_tb.sv =====
module chip8_instruction_execute_tb;
  import c8x_pkg::*;

  localparam int MEM_BYTES  = 4096;
  localparam int STACK_SIZE = 16;
  localparam int ROWS       = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_REQS = 2000;

  localparam logic [7:0] GLYPHS [0:79] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  localparam logic [1:0] CMD_NONE = 2'd3;

  typedef struct {
    logic [1:0]  status;
    logic [11:0] pc;
    logic [7:0]  flag;
    logic [63:0] row;
  } answer_t;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [7:0]  rnd;
    bit          typed;
    answer_t     ans;
  } request_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_command = '0;
  logic [15:0] in_opcode = '0;
  logic [11:0] in_address = '0;
  logic [7:0]  in_data = '0;
  logic [7:0]  in_random_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [11:0] out_program_counter;
  logic [7:0]  out_flag_value;
  logic [63:0] out_row_data;

  // expectation travelling alongside the driven request
  bit      cur_typed = 1'b0;
  answer_t cur_ans;

  // predictor state
  logic [7:0]  vreg [16];
  logic [11:0] index_reg;
  logic [11:0] pc_reg;
  logic [11:0] ret_stack [STACK_SIZE];
  int          depth;
  logic [7:0]  mem [MEM_BYTES];
  logic [63:0] screen [ROWS];

  answer_t answer_q [$];
  int      errors = 0;
  int      idle_cycles = 0;
  int      burst_left = 0;
  request_t directed [$];

  chip8_instruction_execute i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_opcode           (in_opcode),
    .in_address          (in_address),
    .in_data             (in_data),
    .in_random_byte      (in_random_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_program_counter (out_program_counter),
    .out_flag_value      (out_flag_value),
    .out_row_data        (out_row_data)
  );

  always #6 clk = ~clk;

  // Bring the predictor to its post-reset state
  task automatic reset_machine();
    for (int i = 0; i < 16; i++) vreg[i] = '0;
    for (int i = 0; i < STACK_SIZE; i++) ret_stack[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) mem[i] = '0;
    for (int i = 0; i < 80; i++) mem[FONT_BASE + i] = GLYPHS[i];
    for (int i = 0; i < ROWS; i++) screen[i] = '0;
    index_reg = '0;
    pc_reg = PC_START;
    depth = 0;
  endtask

  // XOR a sprite onto the screen, clipped at the edges; returns collision
  function automatic logic [7:0] draw(input logic [3:0] xs, input logic [3:0] ys,
                                      input logic [3:0] rows_n);
    int px, py, yy, xx;
    logic [7:0] bits;
    logic [7:0] hit;
    px = vreg[xs] % SCREEN_WIDTH;
    py = vreg[ys] % ROWS;
    hit = 8'd0;
    for (int r = 0; r < rows_n; r++) begin
      yy = py + r;
      if (yy >= ROWS) break;
      bits = mem[(index_reg + r) % MEM_BYTES];
      for (int c = 0; c < 8; c++) begin
        xx = px + c;
        if (xx >= SCREEN_WIDTH) break;
        if (bits[7 - c]) begin
          if (screen[yy][63 - xx]) hit = 8'd1;
          screen[yy][63 - xx] = ~screen[yy][63 - xx];
        end
      end
    end
    return hit;
  endfunction

  // Work out the answer to one request and advance the predictor state
  task automatic execute_request(input request_t rq, output answer_t ans);
    logic [3:0]  x, y, n;
    logic [7:0]  kk, a, b;
    logic [11:0] nnn;
    logic [8:0]  sum;
    status_t     st;
    x = rq.op[11:8];
    y = rq.op[7:4];
    n = rq.op[3:0];
    kk = rq.op[7:0];
    nnn = rq.op[11:0];
    st = ST_OK;
    ans.row = '0;
    case (rq.cmd)
      CMD_EXEC: begin
        pc_reg = pc_reg + 12'd2;
        case (rq.op[15:12])
          GRP_SYS: begin
            if (rq.op == OP_CLS) begin
              for (int i = 0; i < ROWS; i++) screen[i] = '0;
            end else if (rq.op == OP_RET) begin
              if (depth == 0) st = ST_UNDERFLOW;
              else begin
                depth--;
                pc_reg = ret_stack[depth];
              end
            end else st = ST_BAD;
          end
          GRP_JP: pc_reg = nnn;
          GRP_CALL: begin
            if (depth >= STACK_SIZE) st = ST_OVERFLOW;
            else begin
              ret_stack[depth] = pc_reg;
              depth++;
              pc_reg = nnn;
            end
          end
          GRP_SE:   if (vreg[x] == kk) pc_reg = pc_reg + 12'd2;
          GRP_SNE:  if (vreg[x] != kk) pc_reg = pc_reg + 12'd2;
          GRP_SER:  if (vreg[x] == vreg[y]) pc_reg = pc_reg + 12'd2;
          GRP_SNER: if (vreg[x] != vreg[y]) pc_reg = pc_reg + 12'd2;
          GRP_LD:   vreg[x] = kk;
          GRP_ADD:  vreg[x] = vreg[x] + kk;
          GRP_ALU: begin
            a = vreg[x];
            b = vreg[y];
            case (n)
              ALU_MOV: vreg[x] = b;
              ALU_OR:  vreg[x] = a | b;
              ALU_AND: vreg[x] = a & b;
              ALU_XOR: vreg[x] = a ^ b;
              ALU_ADD: begin
                sum = a + b;
                vreg[x] = sum[7:0];
                vreg[FLAG_REG] = {7'd0, sum[8]};
              end
              ALU_SUB: begin
                vreg[x] = a - b;
                vreg[FLAG_REG] = (a >= b) ? 8'd1 : 8'd0;
              end
              ALU_SHR: begin
                vreg[x] = a >> 1;
                vreg[FLAG_REG] = {7'd0, a[0]};
              end
              ALU_SUBN: begin
                vreg[x] = b - a;
                vreg[FLAG_REG] = (b >= a) ? 8'd1 : 8'd0;
              end
              ALU_SHL: begin
                vreg[x] = a << 1;
                vreg[FLAG_REG] = {7'd0, a[7]};
              end
              default: st = ST_BAD;
            endcase
          end
          GRP_LDI: index_reg = nnn;
          GRP_JPV: pc_reg = vreg[0] + nnn;
          GRP_RND: vreg[x] = rq.rnd & kk;
          GRP_DRW: vreg[FLAG_REG] = draw(x, y, n);
          default: st = ST_BAD;
        endcase
      end
      CMD_WRITE: mem[rq.addr] = rq.data;
      CMD_READ:  if (rq.addr < ROWS) ans.row = screen[rq.addr];
      default:   st = ST_BAD;
    endcase
    ans.status = st;
    ans.pc = pc_reg;
    ans.flag = vreg[FLAG_REG];
  endtask

  function automatic request_t req(input logic [1:0] cmd, input logic [15:0] op,
                                   input logic [11:0] addr, input logic [7:0] data,
                                   input logic [7:0] rnd);
    request_t r;
    r.cmd = cmd;
    r.op = op;
    r.addr = addr;
    r.data = data;
    r.rnd = rnd;
    r.typed = 1'b0;
    r.ans = '{default: '0};
    return r;
  endfunction

  function automatic request_t typed_req(input request_t r, input logic [1:0] st,
                                         input logic [11:0] pc);
    request_t t;
    t = r;
    t.typed = 1'b1;
    t.ans.status = st;
    t.ans.pc = pc;
    t.ans.flag = 8'd0;
    t.ans.row = '0;
    return t;
  endfunction

  // Random opcode, weighted towards sequences that exercise stack and screen
  function automatic logic [15:0] random_opcode();
    int pick;
    logic [15:0] r;
    pick = $urandom_range(0, 99);
    r = 16'($urandom);
    if (pick < 8)       return {GRP_CALL, r[11:0]};
    else if (pick < 14) return OP_RET;
    else if (pick < 16) return OP_CLS;
    else if (pick < 30) return {GRP_ALU, r[11:0]};
    else if (pick < 45) return {GRP_LD, r[11:0]};
    else if (pick < 52) return {GRP_ADD, r[11:0]};
    else if (pick < 58) begin
      case ($urandom_range(0, 3))
        0: return {GRP_SE, r[11:0]};
        1: return {GRP_SNE, r[11:0]};
        2: return {GRP_SER, r[11:0]};
        default: return {GRP_SNER, r[11:0]};
      endcase
    end else if (pick < 63) begin
      if ($urandom_range(0, 1)) return {GRP_LDI, FONT_BASE + 12'($urandom_range(0, 15) * 5)};
      return {GRP_LDI, r[11:0]};
    end else if (pick < 75) return {GRP_DRW, r[11:4], 4'($urandom_range(0, 15))};
    else if (pick < 78) return {GRP_JPV, r[11:0]};
    else if (pick < 82) return {GRP_RND, r[11:0]};
    else if (pick < 85) return {GRP_JP, r[11:0]};
    else if (pick < 90) return r;
    else if (pick < 94) return {4'hE, r[11:0]};
    else if (pick < 97) return {4'hF, r[11:0]};
    return {GRP_SYS, r[11:0]};
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick;
    r = req(CMD_EXEC, random_opcode(), 12'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 6) r.cmd = CMD_WRITE;
    else if (pick < 13) begin
      r.cmd = CMD_READ;
      if ($urandom_range(0, 7) != 0) r.addr = 12'($urandom_range(0, ROWS - 1));
    end else if (pick < 15) r.cmd = CMD_NONE;
    return r;
  endfunction

  // Offer one request, in bursts with random gaps, and hold it until taken
  task automatic send(input request_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= r.cmd;
    in_opcode <= r.op;
    in_address <= r.addr;
    in_data <= r.data;
    in_random_byte <= r.rnd;
    cur_typed <= r.typed;
    cur_ans <= r.ans;
    do @(posedge clk); while (in_stall);
  endtask

  // Stall the result side in phases: free running, light and heavy
  always @(posedge clk) begin : result_stall
    int phase;
    phase = int'(($time / 12 / 97) % 3);
    case (phase)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin : scoreboard
    request_t r;
    answer_t a;
    answer_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        r = req(in_command, in_opcode, in_address, in_data, in_random_byte);
        execute_request(r, a);
        answer_q.push_back(cur_typed ? cur_ans : a);
      end
      if (out_valid && !out_stall) begin
        if (answer_q.size() == 0) begin
          $error("result without a pending request");
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errors++;
          end
          if (out_program_counter !== want.pc) begin
            $error("program_counter: expected %h, got %h", want.pc, out_program_counter);
            errors++;
          end
          if (out_flag_value !== want.flag) begin
            $error("flag_value: expected %h, got %h", want.flag, out_flag_value);
            errors++;
          end
          if (out_row_data !== want.row) begin
            $error("row_data: expected %h, got %h", want.row, out_row_data);
            errors++;
          end
        end
      end
    end
  end

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    reset_machine();
    // after reset, error codes and extremes
    directed.push_back(typed_req(req(CMD_READ, 16'h0000, 12'h000, 8'h00, 8'h00),
                                 ST_OK, 12'h200));
    directed.push_back(typed_req(req(CMD_EXEC, 16'h0123, 12'h000, 8'h00, 8'h00),
                                 ST_BAD, 12'h202));
    directed.push_back(typed_req(req(CMD_EXEC, OP_RET, 12'h000, 8'h00, 8'h00),
                                 ST_UNDERFLOW, 12'h204));
    directed.push_back(typed_req(req(CMD_NONE, 16'hFFFF, 12'hFFF, 8'hFF, 8'hFF),
                                 ST_BAD, 12'h204));
    directed.push_back(typed_req(req(CMD_WRITE, 16'h0000, 12'hFFF, 8'hFF, 8'h00),
                                 ST_OK, 12'h204));
    directed.push_back(typed_req(req(CMD_READ, 16'h0000, 12'hFFF, 8'h00, 8'h00),
                                 ST_OK, 12'h204));
    directed.push_back(typed_req(req(CMD_EXEC, 16'hE09E, 12'h000, 8'h00, 8'h00),
                                 ST_BAD, 12'h206));
    directed.push_back(typed_req(req(CMD_EXEC, 16'hF00A, 12'h000, 8'h00, 8'h00),
                                 ST_BAD, 12'h208));
    // ALU group with the flag as destination, shifts, carry and borrow
    directed.push_back(req(CMD_EXEC, 16'h60FF, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h61FF, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h8014, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h8F15, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h8016, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h811E, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h8017, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h8123, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h8018, 0, 0, 0));
    // sprite clipped at the corner, then drawn again for a collision
    directed.push_back(req(CMD_EXEC, 16'hA050, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h6A3E, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h6B1E, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'hDABF, 0, 0, 0));
    directed.push_back(req(CMD_READ, 16'h0000, 12'h01E, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'hDAB5, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, OP_CLS, 0, 0, 0));
    // call, skips, return, jump plus V0, random mask
    directed.push_back(req(CMD_EXEC, 16'h2FFE, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h3A3E, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'h5AB0, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, OP_RET, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'hB0FF, 0, 0, 0));
    directed.push_back(req(CMD_EXEC, 16'hC3F0, 0, 0, 8'hAA));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send(directed[i]);
    in_valid <= 1'b0;
    cur_typed <= 1'b0;

    // hold off until the directed part has drained
    @(posedge clk);
    wait (answer_q.size() == 0);
    @(posedge clk);

    for (int i = 0; i < RANDOM_REQS; i++) begin
      send(random_request());
      if (i == RANDOM_REQS / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        wait (answer_q.size() == 0);
        @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (answer_q.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
